FILE: src/mqd_pkg.sv
// ----------------------------------------------------------------------------
// mqd_pkg
// Shared types and constants for the mod-q dot product with digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package mqd_pkg;

   localparam int unsigned ACC_W       = 32;
   localparam int unsigned MATRIX_W    = 32;
   localparam int unsigned VECTOR_W    = 3;
   localparam int unsigned COEFF_W     = 23;
   localparam int unsigned DIGEST_W    = 32;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 56;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [ACC_W-1:0]    MOD_Q        = 32'd8380417;
   localparam logic [ACC_W-1:0]    ROUND_HALF   = 32'h0040_0000;
   localparam int unsigned         ROUND_SHIFT  = 23;
   localparam int unsigned         DIGEST_SHIFT = 16;
   localparam logic [DIGEST_W-1:0] FNV_BASIS    = 32'h811c_9dc5;
   localparam logic [DIGEST_W-1:0] FNV_PRIME    = 32'h0100_0193;

   typedef struct packed {
      logic             start;
      logic [ACC_W-1:0] acc;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULQ,
      ST_SUB,
      ST_MUL1,
      ST_MUL2,
      ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

FILE: src/mqd_front.sv
// ----------------------------------------------------------------------------
// mqd_front
// Accepts requests, accumulates products and queues finished sums.
// ----------------------------------------------------------------------------
`default_nettype none

module mqd_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [mqd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                             req_tlast,
   input  wire logic                             req_tuser,
   input  wire mqd_pkg::queue_status_type        queue_status,
   output logic                                  push,
   output mqd_pkg::queue_entry_type              push_entry
);

   logic [mqd_pkg::ACC_W-1:0]    acc_ff;
   logic [mqd_pkg::ACC_W-1:0]    acc_in;
   logic                         start_pend_ff;
   logic                         start_pend_in;
   logic                         accept;
   logic [mqd_pkg::MATRIX_W-1:0] matrix_coeff;
   logic [mqd_pkg::VECTOR_W-1:0] vector_coeff;
   logic [mqd_pkg::ACC_W-1:0]    vector_ext;
   logic [mqd_pkg::ACC_W-1:0]    product;
   logic [mqd_pkg::ACC_W-1:0]    sum;

   assign req_tready   = !queue_status.full;
   assign accept       = req_tvalid && req_tready;
   assign matrix_coeff = req_tdata[mqd_pkg::MATRIX_W-1:0];
   assign vector_coeff = req_tdata[mqd_pkg::MATRIX_W +: mqd_pkg::VECTOR_W];
   assign vector_ext   = {{(mqd_pkg::ACC_W-mqd_pkg::VECTOR_W){vector_coeff[mqd_pkg::VECTOR_W-1]}},
                          vector_coeff};
   assign product      = matrix_coeff * vector_ext;
   assign sum          = acc_ff + product;

   always_comb begin
      acc_in           = acc_ff;
      start_pend_in    = start_pend_ff;
      push             = 1'b0;
      push_entry.acc   = sum;
      push_entry.start = start_pend_ff || req_tuser;
      if (accept) begin
         if (req_tlast) begin
            push          = 1'b1;
            acc_in        = '0;
            start_pend_in = 1'b0;
         end else begin
            acc_in        = sum;
            start_pend_in = start_pend_ff || req_tuser;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         start_pend_ff <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         start_pend_ff <= start_pend_in;
      end
   end

   // closing a sum always leaves a cleared accumulator
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (acc_ff == '0))
      else $error("accumulator not cleared after last term");

endmodule

`default_nettype wire

FILE: src/mqd_queue.sv
// ----------------------------------------------------------------------------
// mqd_queue
// Short queue of finished sums between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mqd_queue #(
   parameter int unsigned DEPTH = mqd_pkg::QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire mqd_pkg::queue_entry_type  push_entry,
   input  wire logic                      pop,
   output mqd_pkg::queue_entry_type       head_entry,
   output mqd_pkg::queue_status_type      status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mqd_pkg::queue_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff;
   logic [PTR_W-1:0]         wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff;
   logic [PTR_W-1:0]         rd_ptr_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign head_entry   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: src/mqd_back.sv
// ----------------------------------------------------------------------------
// mqd_back
// Reduces each finished sum mod q, folds it into the digest and emits it.
// ----------------------------------------------------------------------------
`default_nettype none

module mqd_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mqd_pkg::queue_entry_type        head_entry,
   input  wire mqd_pkg::queue_status_type       queue_status,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [mqd_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int unsigned T_W = mqd_pkg::ACC_W - mqd_pkg::ROUND_SHIFT;

   mqd_pkg::back_state_type      state_ff;
   mqd_pkg::back_state_type      state_in;
   logic [mqd_pkg::ACC_W-1:0]    acc_ff;
   logic [mqd_pkg::ACC_W-1:0]    acc_in;
   logic                         start_ff;
   logic                         start_in;
   logic [mqd_pkg::ACC_W-1:0]    tq_ff;
   logic [mqd_pkg::ACC_W-1:0]    tq_in;
   logic [mqd_pkg::COEFF_W-1:0]  x_ff;
   logic [mqd_pkg::COEFF_W-1:0]  x_in;
   logic [mqd_pkg::DIGEST_W-1:0] h_ff;
   logic [mqd_pkg::DIGEST_W-1:0] h_in;
   logic [mqd_pkg::DIGEST_W-1:0] digest_ff;
   logic [mqd_pkg::DIGEST_W-1:0] digest_in;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [mqd_pkg::COEFF_W-1:0]  out_coeff_ff;
   logic [mqd_pkg::COEFF_W-1:0]  out_coeff_in;
   logic [mqd_pkg::DIGEST_W-1:0] out_digest_ff;
   logic [mqd_pkg::DIGEST_W-1:0] out_digest_in;

   logic [mqd_pkg::ACC_W-1:0]    rounded;
   logic [mqd_pkg::ACC_W-1:0]    t_ext;
   logic [mqd_pkg::ACC_W-1:0]    diff;
   logic [mqd_pkg::ACC_W-1:0]    diff_fix;
   logic [mqd_pkg::DIGEST_W-1:0] x_wide;
   logic [mqd_pkg::DIGEST_W-1:0] x_high;

   assign rounded  = acc_ff + mqd_pkg::ROUND_HALF;
   assign t_ext    = {{(mqd_pkg::ACC_W-T_W){rounded[mqd_pkg::ACC_W-1]}},
                      rounded[mqd_pkg::ACC_W-1 -: T_W]};
   assign diff     = acc_ff - tq_ff;
   assign diff_fix = diff + mqd_pkg::MOD_Q;
   assign x_wide   = {{(mqd_pkg::DIGEST_W-mqd_pkg::COEFF_W){1'b0}}, x_ff};
   assign x_high   = x_wide >> mqd_pkg::DIGEST_SHIFT;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_digest_ff, out_coeff_ff};

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      start_in      = start_ff;
      tq_in         = tq_ff;
      x_in          = x_ff;
      h_in          = h_ff;
      digest_in     = digest_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_coeff_in  = out_coeff_ff;
      out_digest_in = out_digest_ff;
      pop           = 1'b0;
      case (state_ff)
         mqd_pkg::ST_IDLE: begin
            if (!queue_status.empty) begin
               pop      = 1'b1;
               acc_in   = head_entry.acc;
               start_in = head_entry.start;
               state_in = mqd_pkg::ST_MULQ;
            end
         end
         mqd_pkg::ST_MULQ: begin
            tq_in    = t_ext * mqd_pkg::MOD_Q;
            state_in = mqd_pkg::ST_SUB;
         end
         mqd_pkg::ST_SUB: begin
            x_in     = diff[mqd_pkg::ACC_W-1] ? diff_fix[mqd_pkg::COEFF_W-1:0]
                                              : diff[mqd_pkg::COEFF_W-1:0];
            h_in     = start_ff ? mqd_pkg::FNV_BASIS : digest_ff;
            state_in = mqd_pkg::ST_MUL1;
         end
         mqd_pkg::ST_MUL1: begin
            h_in     = (h_ff ^ x_wide) * mqd_pkg::FNV_PRIME;
            state_in = mqd_pkg::ST_MUL2;
         end
         mqd_pkg::ST_MUL2: begin
            h_in     = (h_ff ^ x_high) * mqd_pkg::FNV_PRIME;
            state_in = mqd_pkg::ST_EMIT;
         end
         mqd_pkg::ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in  = 1'b1;
               out_coeff_in  = x_ff;
               out_digest_in = h_ff;
               digest_in     = h_ff;
               state_in      = mqd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mqd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mqd_pkg::ST_IDLE;
         digest_ff    <= mqd_pkg::FNV_BASIS;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         digest_ff    <= digest_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      start_ff      <= start_in;
      tq_ff         <= tq_in;
      x_ff          <= x_in;
      h_ff          <= h_in;
      out_coeff_ff  <= out_coeff_in;
      out_digest_ff <= out_digest_in;
   end

   // reduced coefficient is frozen into 0..q-1 before the digest fold
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqd_pkg::ST_MUL1) |-> ({9'b0, x_ff} < mqd_pkg::MOD_Q))
      else $error("reduced coefficient out of range");

   // a new response only appears right after the emit step
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !$past(out_valid_ff && !rsp_tready) && !$past(reset))
         |-> ($past(state_ff) == mqd_pkg::ST_EMIT))
      else $error("response without emit step");

   // the queue is only drained from idle
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == mqd_pkg::ST_IDLE) && !queue_status.empty)
      else $error("pop outside idle");

endmodule

`default_nettype wire

FILE: src/mod_q_dot_product_with_digest.sv
// ----------------------------------------------------------------------------
// mod_q_dot_product_with_digest
// Multiply-accumulate of matrix and small vector coefficients, reduced mod q
// and folded into a running digest per output coefficient.
//
// req channel: one term per request, tdata = matrix coeff and vector coeff,
// tlast closes a sum, tuser restarts the digest for a new output vector.
// rsp channel: one response per closed sum, reduced coeff and digest.
// Terms that do not close a sum are taken one per cycle while the queue is
// not full. A closed sum is queued and worked off by the back part in the
// steps pop, t*q multiply, subtract and freeze, two digest multiplies and
// emit; the back part takes a new sum from the queue only after it has
// emitted the last one. The queue holds QUEUE_DEPTH sums; req_tready drops
// while it is full. The response register holds while rsp_tready is low,
// and the back part finishes the next sum behind it meanwhile.
// Reset clears the accumulator, empties the queue and loads the digest
// with its offset basis.
// ----------------------------------------------------------------------------
`default_nettype none

module mod_q_dot_product_with_digest #(
   parameter int unsigned QUEUE_DEPTH = mqd_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // matrix_coeff[31:0], vector_coeff[34:32], zero fill
   input  wire logic [mqd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tlast,
   // start_vector
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // reduced_coeff[22:0], running_digest[54:23], zero fill
   output logic [mqd_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   logic                       push;
   logic                       pop;
   mqd_pkg::queue_entry_type   push_entry;
   mqd_pkg::queue_entry_type   head_entry;
   mqd_pkg::queue_status_type  queue_status;

   mqd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .req_tuser    (req_tuser),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   mqd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   mqd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

`default_nettype wire
